[sv/tvp_pkg.sv]
package tvp_pkg;

    // Field widths
    localparam int TIME_W = 16;   // elapsed / duration ticks
    localparam int FRAC_W = 16;   // fraction bits of position
    localparam int PEAK_W = 16;   // peak_fraction, Q0.16
    localparam int DATA_W = 32;   // start_value, distance
    localparam int POS_W  = 48;   // position, Q32.16

    // Datapath widths
    localparam int PROD_W = 64;   // distance * s^2
    localparam int DEN_W  = 48;   // T^2 * P, below 2^48
    localparam int MP_W   = 17;   // widest serial multiplier (Q = 2^16 - P)
    localparam int QUOT_W = 48;   // quotient stays below 2^47
    localparam int SUM_W  = 50;   // profile and position before saturation
    localparam int CNT_W  = 7;

    // Step counts, one multiplier bit or one quotient bit per cycle
    localparam int MUL_STEPS = MP_W + 1;
    localparam int DIV_STEPS = PROD_W + FRAC_W + PEAK_W;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    localparam logic signed [SUM_W-1:0] POS_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] POS_MIN = 50'sh3_8000_0000_0000;

    // Configuration register indexes
    localparam logic [1:0] REG_START    = 2'd0;
    localparam logic [1:0] REG_DISTANCE = 2'd1;
    localparam logic [1:0] REG_DURATION = 2'd2;
    localparam logic [1:0] REG_PEAK     = 2'd3;

    // Input word function codes
    localparam logic FUNC_ADVANCE = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,   // T*T and T*P
        ST_MUL2,   // |D|*s and T^2*(P or Q)
        ST_MUL3,   // (|D|*s)*s
        ST_DIV,    // restoring divide, one quotient bit per cycle
        ST_FIN,    // apply sign and phase
        ST_HOLD    // add start, saturate, wait for output slot
    } state_t;

endpackage

[sv/triangular_velocity_profile.sv]
// Flow: an accepted word passes ST_MUL1, ST_MUL2, ST_MUL3, ST_DIV, ST_FIN and
//   ST_HOLD before m_valid rises, plus any wait in ST_HOLD while the previous
//   result word is still held on the output. s_ready is high only in ST_IDLE,
//   so a new word is taken only after the last has left ST_HOLD. Most of that
//   time is the bit-serial divider and three shift-add multiply passes on acc_reg.
// Reset (aresetn low, synchronous): elapsed = 0, registers = 0, 0, 1, 32768,
//   no word in flight, m_valid low.
module triangular_velocity_profile (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // tick / restart words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [15:0] s_dt,

    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_position,
    output logic [15:0] m_elapsed,
    output logic        m_done_res
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [tvp_pkg::DATA_W-1:0] start_reg;
    logic signed [tvp_pkg::DATA_W-1:0] dist_reg;
    logic [tvp_pkg::TIME_W-1:0]        dur_reg;
    logic [tvp_pkg::PEAK_W-1:0]        peak_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            dist_reg  <= '0;
            dur_reg   <= tvp_pkg::TIME_W'(1);
            peak_reg  <= tvp_pkg::PEAK_W'(32768);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tvp_pkg::REG_START:    start_reg <= cfg_data;
                tvp_pkg::REG_DISTANCE: dist_reg  <= cfg_data;
                tvp_pkg::REG_DURATION: dur_reg   <= cfg_data[tvp_pkg::TIME_W-1:0];
                tvp_pkg::REG_PEAK:     peak_reg  <= cfg_data[tvp_pkg::PEAK_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    tvp_pkg::state_t state_reg, state_next;

    logic [tvp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [tvp_pkg::TIME_W-1:0] elapsed_reg, elapsed_next;

    // Serial multiply / divide datapath
    logic [tvp_pkg::PROD_W-1:0] mc_reg, mc_next;     // multiplicand, shifts left
    logic [tvp_pkg::DEN_W-1:0]  mc2_reg, mc2_next;   // second multiplicand
    logic [tvp_pkg::MP_W-1:0]   mp_reg, mp_next;     // multiplier, shifts right
    logic [tvp_pkg::MP_W-1:0]   mp2_reg, mp2_next;
    logic [tvp_pkg::PROD_W-1:0] acc_reg, acc_next;   // T^2, |D|*s, M, then dividend
    logic [tvp_pkg::DEN_W-1:0]  acc2_reg, acc2_next; // T*P, then divisor
    logic [tvp_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [tvp_pkg::QUOT_W-1:0] quot_reg, quot_next;
    logic [tvp_pkg::TIME_W-1:0] s_reg, s_next;       // t or T-t
    logic                       fall_reg, fall_next; // decelerating phase
    logic signed [tvp_pkg::SUM_W-1:0] prof_reg, prof_next;

    // Output register
    logic                       m_valid_reg, m_valid_next;
    logic [tvp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [tvp_pkg::TIME_W-1:0] m_elapsed_reg, m_elapsed_next;
    logic                       m_done_reg, m_done_next;

    // Control decodes
    logic in_accept;
    logic out_load;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tvp_pkg::ST_IDLE: if (s_valid) state_next = tvp_pkg::ST_MUL1;
            tvp_pkg::ST_MUL1: if (cnt_reg == tvp_pkg::MUL_LAST) state_next = tvp_pkg::ST_MUL2;
            tvp_pkg::ST_MUL2: if (cnt_reg == tvp_pkg::MUL_LAST) state_next = tvp_pkg::ST_MUL3;
            tvp_pkg::ST_MUL3: if (cnt_reg == tvp_pkg::MUL_LAST) state_next = tvp_pkg::ST_DIV;
            tvp_pkg::ST_DIV:  if (cnt_reg == tvp_pkg::DIV_LAST) state_next = tvp_pkg::ST_FIN;
            tvp_pkg::ST_FIN:  state_next = tvp_pkg::ST_HOLD;
            tvp_pkg::ST_HOLD: if (!m_valid_reg || m_ready) state_next = tvp_pkg::ST_IDLE;
            default:          state_next = tvp_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            tvp_pkg::ST_IDLE: s_ready  = 1'b1;
            tvp_pkg::ST_HOLD: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
        in_accept = s_valid && s_ready;
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [tvp_pkg::TIME_W:0]          t_sum;
    logic [tvp_pkg::DATA_W-1:0]        mag;
    logic [31:0]                       t_scaled;
    logic                              fall_dec;
    logic [tvp_pkg::TIME_W-1:0]        s_dec;
    logic [tvp_pkg::MP_W-1:0]          pq_dec;
    logic [tvp_pkg::DEN_W-1:0]         add2;
    logic [tvp_pkg::DEN_W:0]           rem_sh;
    logic [tvp_pkg::DEN_W:0]           rem_sub;
    logic                              q_bit;
    logic [tvp_pkg::QUOT_W-1:0]        q_val;
    logic signed [tvp_pkg::SUM_W-1:0]  full;
    logic signed [tvp_pkg::SUM_W-1:0]  q_ext;
    logic signed [tvp_pkg::SUM_W-1:0]  start_ext;
    logic signed [tvp_pkg::SUM_W-1:0]  pos_sum;

    always_comb begin
        cnt_next       = cnt_reg + tvp_pkg::CNT_W'(1);
        elapsed_next   = elapsed_reg;
        mc_next        = mc_reg << 1;
        mc2_next       = mc2_reg << 1;
        mp_next        = mp_reg >> 1;
        mp2_next       = mp2_reg >> 1;
        acc_next       = acc_reg;
        acc2_next      = acc2_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        s_next         = s_reg;
        fall_next      = fall_reg;
        prof_next      = prof_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        pos_next       = pos_reg;
        m_elapsed_next = m_elapsed_reg;
        m_done_next    = m_done_reg;

        // new elapsed time, clamped to duration
        t_sum = {1'b0, elapsed_reg} + {1'b0, s_dt};

        // |distance|; -2^31 maps to 2^31 as unsigned
        mag = dist_reg[tvp_pkg::DATA_W-1] ? (tvp_pkg::DATA_W'(0) - dist_reg) : dist_reg;

        // phase select: rising while t*2^16 <= T*P
        t_scaled = {elapsed_reg, tvp_pkg::PEAK_W'(0)};
        fall_dec = t_scaled > acc2_reg[31:0];
        s_dec    = fall_dec ? (dur_reg - elapsed_reg) : elapsed_reg;
        pq_dec   = fall_dec ? (tvp_pkg::MP_W'(1 << tvp_pkg::PEAK_W) - {1'b0, peak_reg})
                            : {1'b0, peak_reg};

        // second accumulator takes T in pass 1, T^2 in pass 2
        add2 = (state_reg == tvp_pkg::ST_MUL1) ? mc_reg[tvp_pkg::DEN_W-1:0] : mc2_reg;

        // restoring divide step
        rem_sh  = {rem_reg, acc_reg[tvp_pkg::PROD_W-1]};
        rem_sub = rem_sh - {1'b0, acc2_reg};
        q_bit   = rem_sh >= {1'b0, acc2_reg};

        // final quotient; zero divisor yields zero
        q_val = (acc2_reg == '0) ? '0 : quot_reg;
        q_ext = $signed({{(tvp_pkg::SUM_W - tvp_pkg::QUOT_W){1'b0}}, q_val});
        full  = $signed({{(tvp_pkg::SUM_W - tvp_pkg::DATA_W - tvp_pkg::FRAC_W)
                          {dist_reg[tvp_pkg::DATA_W-1]}},
                         dist_reg, tvp_pkg::FRAC_W'(0)});
        start_ext = $signed({{(tvp_pkg::SUM_W - tvp_pkg::DATA_W - tvp_pkg::FRAC_W)
                              {start_reg[tvp_pkg::DATA_W-1]}},
                             start_reg, tvp_pkg::FRAC_W'(0)});
        pos_sum = start_ext + prof_reg;

        case (state_reg)
            tvp_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (in_accept) begin
                    if (s_func == tvp_pkg::FUNC_RESTART) begin
                        elapsed_next = '0;
                    end else if (t_sum > {1'b0, dur_reg}) begin
                        elapsed_next = dur_reg;
                    end else begin
                        elapsed_next = t_sum[tvp_pkg::TIME_W-1:0];
                    end
                    mc_next   = tvp_pkg::PROD_W'(dur_reg);
                    mp_next   = tvp_pkg::MP_W'(dur_reg);
                    mp2_next  = tvp_pkg::MP_W'(peak_reg);
                    acc_next  = '0;
                    acc2_next = '0;
                end
            end
            tvp_pkg::ST_MUL1: begin
                acc_next  = acc_reg + (mp_reg[0] ? mc_reg : '0);
                acc2_next = acc2_reg + (mp2_reg[0] ? add2 : '0);
                if (cnt_reg == tvp_pkg::MUL_LAST) begin
                    cnt_next  = '0;
                    fall_next = fall_dec;
                    s_next    = s_dec;
                    mc_next   = tvp_pkg::PROD_W'(mag);
                    mc2_next  = tvp_pkg::DEN_W'(acc_reg[31:0]);
                    mp_next   = tvp_pkg::MP_W'(s_dec);
                    mp2_next  = pq_dec;
                    acc_next  = '0;
                    acc2_next = '0;
                end
            end
            tvp_pkg::ST_MUL2: begin
                acc_next  = acc_reg + (mp_reg[0] ? mc_reg : '0);
                acc2_next = acc2_reg + (mp2_reg[0] ? add2 : '0);
                if (cnt_reg == tvp_pkg::MUL_LAST) begin
                    cnt_next = '0;
                    mc_next  = tvp_pkg::PROD_W'(acc_reg[tvp_pkg::POS_W-1:0]);
                    mp_next  = tvp_pkg::MP_W'(s_reg);
                    acc_next = '0;
                end
            end
            tvp_pkg::ST_MUL3: begin
                acc_next = acc_reg + (mp_reg[0] ? mc_reg : '0);
                if (cnt_reg == tvp_pkg::MUL_LAST) begin
                    cnt_next  = '0;
                    rem_next  = '0;
                    quot_next = '0;
                end
            end
            tvp_pkg::ST_DIV: begin
                acc_next  = acc_reg << 1;
                rem_next  = q_bit ? rem_sub[tvp_pkg::DEN_W-1:0] : rem_sh[tvp_pkg::DEN_W-1:0];
                quot_next = {quot_reg[tvp_pkg::QUOT_W-2:0], q_bit};
            end
            tvp_pkg::ST_FIN: begin
                if (dur_reg == '0) begin
                    prof_next = full;
                end else if (!fall_reg) begin
                    prof_next = dist_reg[tvp_pkg::DATA_W-1] ? -q_ext : q_ext;
                end else begin
                    prof_next = dist_reg[tvp_pkg::DATA_W-1] ? (full + q_ext) : (full - q_ext);
                end
            end
            tvp_pkg::ST_HOLD: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    if (pos_sum > tvp_pkg::POS_MAX) begin
                        pos_next = tvp_pkg::POS_MAX[tvp_pkg::POS_W-1:0];
                    end else if (pos_sum < tvp_pkg::POS_MIN) begin
                        pos_next = tvp_pkg::POS_MIN[tvp_pkg::POS_W-1:0];
                    end else begin
                        pos_next = pos_sum[tvp_pkg::POS_W-1:0];
                    end
                    m_elapsed_next = elapsed_reg;
                    m_done_next    = elapsed_reg == dur_reg;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tvp_pkg::ST_IDLE;
            cnt_reg     <= '0;
            elapsed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            elapsed_reg <= elapsed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mc_reg        <= mc_next;
        mc2_reg       <= mc2_next;
        mp_reg        <= mp_next;
        mp2_reg       <= mp2_next;
        acc_reg       <= acc_next;
        acc2_reg      <= acc2_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        s_reg         <= s_next;
        fall_reg      <= fall_next;
        prof_reg      <= prof_next;
        pos_reg       <= pos_next;
        m_elapsed_reg <= m_elapsed_next;
        m_done_reg    <= m_done_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_position = pos_reg;
    assign m_elapsed  = m_elapsed_reg;
    assign m_done_res = m_done_reg;

endmodule

[sv/tvp_checker.sv]
module tvp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [47:0] m_position,
    input logic [15:0] m_elapsed,
    input logic        m_done_res
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position)
                                && $stable(m_elapsed) && $stable(m_done_res))
        else $error("result word changed while stalled");

    // reset empties the output
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // one word in flight: busy right after accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // no result the cycle after accept when output was empty
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

endmodule

bind triangular_velocity_profile tvp_checker u_tvp_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_position (m_position),
    .m_elapsed  (m_elapsed),
    .m_done_res (m_done_res)
);

[tb/tb_triangular_velocity_profile.sv]
module tb_triangular_velocity_profile;
    import tvp_pkg::*;

    // Run shape
    localparam int PHASES       = 17;     // random phases, one register setting each
    localparam int PHASE_WORDS  = 50;     // tick/restart words per phase
    localparam int HOLD_PHASE   = 3;      // receiver holds off, sender keeps offering
    localparam int STEADY_PHASE = 5;      // no idling on either side
    localparam int PAUSE_PHASE  = 8;      // sender stops until the block has emptied
    localparam int HOLD_CYCLES  = 600;    // several times the latency of one word
    localparam int END_WAIT     = 300;    // catches late or stray result words
    localparam int PRINT_MAX    = 40;

    localparam longint POS_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint POS_BOTTOM = -POS_TOP - 1;

    // One result word as the block returns it
    typedef struct packed {
        logic [47:0] position;
        logic [15:0] elapsed;
        logic        done;
    } sample_t;

    // Directed script: a register write or a word, with an optional hand-typed result
    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [31:0] data;
        logic        func;
        logic [15:0] dt;
        logic        chk;
        logic [47:0] pos;
        logic [15:0] el;
        logic        done;
    } script_row_t;

    localparam int SCRIPT_LEN = 38;

    // Registers reset to start 0, distance 0, duration 1, peak 1/2.
    script_row_t script_rows [SCRIPT_LEN] = '{
        // straight out of reset
        '{ROW_WORD, REG_START, 32'h0, FUNC_RESTART, 16'd0, 1'b1, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd0, 1'b1, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'hFFFF, 1'b1, 48'h0, 16'd1, 1'b1},
        // largest start and travel, upper data bits junk on 16-bit registers
        '{ROW_REG, REG_START, 32'h7FFF_FFFF, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_REG, REG_DISTANCE, 32'h7FFF_FFFF, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_REG, REG_DURATION, 32'hA5A5_FFFF, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_REG, REG_PEAK, 32'h5A5A_8000, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_RESTART, 16'd0,
          1'b1, 48'h7FFF_FFFF_0000, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd1234, 1'b0, 48'h0, 16'd0, 1'b0},
        // end of travel overflows the top: saturate
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'hFFFF,
          1'b1, 48'h7FFF_FFFF_FFFF, 16'hFFFF, 1'b1},
        // most negative start and travel: saturate at the bottom
        '{ROW_REG, REG_START, 32'h8000_0000, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_REG, REG_DISTANCE, 32'h8000_0000, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd0,
          1'b1, 48'h8000_0000_0000, 16'hFFFF, 1'b1},
        '{ROW_WORD, REG_START, 32'h0, FUNC_RESTART, 16'd0,
          1'b1, 48'h8000_0000_0000, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd300, 1'b0, 48'h0, 16'd0, 1'b0},
        // short motion, peak at half: midpoint sits at half the travel
        '{ROW_REG, REG_START, 32'h0, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_REG, REG_DISTANCE, 32'd1000, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_REG, REG_DURATION, 32'd100, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_RESTART, 16'd0, 1'b1, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd50,
          1'b1, 48'h0000_01F4_0000, 16'd50, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd30, 1'b0, 48'h0, 16'd0, 1'b0},
        // duration cut below elapsed: next tick clamps to the new end
        '{ROW_REG, REG_DURATION, 32'd40, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd0,
          1'b1, 48'h0000_03E8_0000, 16'd40, 1'b1},
        // negative travel
        '{ROW_REG, REG_DISTANCE, 32'hFFFF_FC18, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_REG, REG_DURATION, 32'd100, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_RESTART, 16'd0, 1'b1, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd50,
          1'b1, 48'hFFFF_FE0C_0000, 16'd50, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd7, 1'b0, 48'h0, 16'd0, 1'b0},
        // peak fraction zero: all deceleration
        '{ROW_REG, REG_PEAK, 32'h0, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_RESTART, 16'd0, 1'b1, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd1, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd99,
          1'b1, 48'hFFFF_FC18_0000, 16'd100, 1'b1},
        // peak fraction at its top: all acceleration
        '{ROW_REG, REG_PEAK, 32'hFFFF_FFFF, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_RESTART, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd99, 1'b0, 48'h0, 16'd0, 1'b0},
        // duration zero: finished from the start, full travel
        '{ROW_REG, REG_DURATION, 32'h0, FUNC_ADVANCE, 16'd0, 1'b0, 48'h0, 16'd0, 1'b0},
        '{ROW_WORD, REG_START, 32'h0, FUNC_ADVANCE, 16'd5,
          1'b1, 48'hFFFF_FC18_0000, 16'd0, 1'b1},
        '{ROW_WORD, REG_START, 32'h0, FUNC_RESTART, 16'd0,
          1'b1, 48'hFFFF_FC18_0000, 16'd0, 1'b1}
    };

    // DUT signals; the inputs are all known from time zero
    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_START;
    logic [31:0] cfg_data  = 32'h0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic        s_func    = FUNC_ADVANCE;
    logic [15:0] s_dt      = 16'h0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [47:0] m_position;
    logic [15:0] m_elapsed;
    logic        m_done_res;

    // Hand-typed result riding along with the payload of a directed word
    logic        tbl_chk  = 1'b0;
    logic [47:0] tbl_pos  = 48'h0;
    logic [15:0] tbl_el   = 16'h0;
    logic        tbl_done = 1'b0;

    // Flow control between processes
    logic        steady   = 1'b0;   // no idling on either side
    int          hold_req = 0;      // bumped by the sender to ask for a long hold-off
    int          hold_ack = 0;
    int          hold_left = 0;

    int          words_sent    = 0;
    int          samples_seen  = 0;
    int          mismatch_count = 0;

    // Predictor state: its own copy of the registers and elapsed ticks
    logic signed [31:0] start_r;
    logic signed [31:0] dist_r;
    logic [15:0]        dur_r;
    logic [15:0]        peak_r;
    logic [15:0]        elapsed_r;
    sample_t            sample_q[$];   // predicted motion samples, oldest first
    sample_t            got;
    sample_t            want;

    triangular_velocity_profile dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_dt       (s_dt),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_position (m_position),
        .m_elapsed  (m_elapsed),
        .m_done_res (m_done_res)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_MAX) $display("%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Travel F(t) in Q.16, truncated on the magnitude, sign of distance applied after.
    function automatic longint travel_at(input logic [15:0] t);
        longint       d64;
        longint       full;
        logic [63:0]  mag;
        logic [63:0]  s;
        logic [63:0]  den;
        logic [63:0]  q;
        logic [127:0] num;
        logic         rising;
        d64  = longint'(dist_r);
        mag  = (d64 < 0) ? 64'(-d64) : 64'(d64);
        full = d64 * 65536;
        if (dur_r == 16'd0) return full;   // zero duration: already at the end
        rising = ({48'd0, t} << PEAK_W) <= {48'd0, dur_r} * {48'd0, peak_r};
        s   = rising ? {48'd0, t} : {48'd0, dur_r} - {48'd0, t};
        den = {48'd0, dur_r} * {48'd0, dur_r}
              * (rising ? {48'd0, peak_r} : 64'd65536 - {48'd0, peak_r});
        num = {64'd0, mag * s * s} << (FRAC_W + PEAK_W);
        // zero peak fraction leaves a zero divisor only at t = 0, where F is 0
        q   = (den == 64'd0) ? 64'd0 : 64'(num / {64'd0, den});
        if (rising) return (d64 < 0) ? -longint'(q) : longint'(q);
        return (d64 < 0) ? full + longint'(q) : full - longint'(q);
    endfunction

    // Advance the elapsed count for one word and give the sample it produces.
    function automatic sample_t sample_after(input logic func, input logic [15:0] dt);
        int unsigned t;
        longint      pos;
        sample_t     smp;
        if (func == FUNC_RESTART) begin
            t = 0;
        end else begin
            t = elapsed_r + dt;
            if (t > dur_r) t = dur_r;
        end
        elapsed_r = 16'(t);
        pos = longint'(start_r) * 65536 + travel_at(elapsed_r);
        if (pos > POS_TOP) pos = POS_TOP;
        if (pos < POS_BOTTOM) pos = POS_BOTTOM;
        smp.position = pos[47:0];
        smp.elapsed  = elapsed_r;
        smp.done     = (elapsed_r == dur_r);
        return smp;
    endfunction

    // Monitor: everything sampled at the edge, in one process, so order of
    // register writes, accepted words and result words is fixed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            start_r   = 32'sd0;
            dist_r    = 32'sd0;
            dur_r     = 16'd1;
            peak_r    = 16'd32768;
            elapsed_r = 16'd0;
        end else begin
            if (m_valid && m_ready) begin
                samples_seen <= samples_seen + 1;
                got = '{m_position, m_elapsed, m_done_res};
                if (sample_q.size() == 0) begin
                    report_mismatch($sformatf("result word with none pending: %h", got));
                end else begin
                    want = sample_q.pop_front();
                    if (got.position !== want.position)
                        report_mismatch($sformatf("position %h, want %h",
                                                  got.position, want.position));
                    if (got.elapsed !== want.elapsed)
                        report_mismatch($sformatf("elapsed %0d, want %0d",
                                                  got.elapsed, want.elapsed));
                    if (got.done !== want.done)
                        report_mismatch($sformatf("done_res %b, want %b",
                                                  got.done, want.done));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START:    start_r = cfg_data;
                    REG_DISTANCE: dist_r  = cfg_data;
                    REG_DURATION: dur_r   = cfg_data[15:0];
                    REG_PEAK:     peak_r  = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                want = sample_after(s_func, s_dt);
                // directed rows with a typed result override the computed one
                if (tbl_chk) want = '{tbl_pos, tbl_el, tbl_done};
                sample_q.push_back(want);
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off counted here.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 32);
        end
    end

    // Stop offering words and wait until every word sent has its result back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (samples_seen != words_sent) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one word after a random gap; returns at the edge that takes it.
    task automatic send_word(input logic func, input logic [15:0] dt, input logic chk,
                             input logic [47:0] pos, input logic [15:0] el,
                             input logic done);
        while (!steady && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_func   <= func;
        s_dt     <= dt;
        tbl_chk  <= chk;
        tbl_pos  <= pos;
        tbl_el   <= el;
        tbl_done <= done;
        words_sent++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_wide();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4:    return $urandom;
            default: return 32'($urandom_range(2000)) - 32'd1000;
        endcase
    endfunction

    // Mostly short motions so that the end of travel is reached often
    function automatic logic [15:0] pick_dur();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(300, 2));
        endcase
    endfunction

    function automatic logic [15:0] pick_peak();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'h8000;
            default: return 16'($urandom_range(65535, 1));
        endcase
    endfunction

    // Step sizes scaled to the motion so both phases get many samples
    function automatic logic [15:0] pick_dt(input logic [15:0] dur);
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            3, 4:    return 16'($urandom_range(dur, 0));
            default: return 16'($urandom_range(dur / 8 + 1, 0));
        endcase
    endfunction

    initial begin
        script_row_t row;
        logic [15:0] cur_dur;
        logic        func;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed script
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            row = script_rows[i];
            if (row.kind == ROW_REG)
                set_reg(row.idx, row.data);
            else
                send_word(row.func, row.dt, row.chk, row.pos, row.el, row.done);
        end

        // random phases; first two: all at their top, then at 1 or the signed minimum
        for (int ph = 0; ph < PHASES; ph++) begin
            cur_dur = (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'd1 : pick_dur();
            set_reg(REG_START, (ph == 0) ? 32'h7FFF_FFFF :
                               (ph == 1) ? 32'h8000_0000 : pick_wide());
            set_reg(REG_DISTANCE, (ph == 0) ? 32'h7FFF_FFFF :
                                  (ph == 1) ? 32'h8000_0000 : pick_wide());
            set_reg(REG_DURATION, {16'($urandom), cur_dur});
            set_reg(REG_PEAK, {16'($urandom), (ph == 0) ? 16'hFFFF :
                                              (ph == 1) ? 16'd1 : pick_peak()});
            if (ph == STEADY_PHASE) steady <= 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (ph == HOLD_PHASE && n == 4) hold_req <= hold_req + 1;
                if (ph == PAUSE_PHASE && n == PHASE_WORDS / 2) wait_idle();
                func = ($urandom_range(99) < 10) ? FUNC_RESTART : FUNC_ADVANCE;
                send_word(func, pick_dt(cur_dur), 1'b0, 48'h0, 16'd0, 1'b0);
            end
            if (ph == STEADY_PHASE) steady <= 1'b0;
        end

        wait_idle();
        repeat (END_WAIT) @(posedge aclk);
        if (sample_q.size() != 0)
            report_mismatch($sformatf("%0d result words never came", sample_q.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #12_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
sv/tvp_pkg.sv
sv/triangular_velocity_profile.sv
sv/tvp_checker.sv
tb/tb_triangular_velocity_profile.sv
